>>> rtl/core/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg: shared codes and types of the shifting array list
// Operation codes, status codes, cell modes and the cell control struct.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int DATA_W       = 32;
  localparam int FUNC_W       = 3;
  localparam int POS_W        = 5;
  localparam int COUNT_OUT_W  = 5;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ       = 3'd5;
  localparam logic [FUNC_W-1:0] FN_WRITE      = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // what every cell of the chain does at each clock edge
  localparam logic [1:0] CM_HOLD      = 2'd0;
  localparam logic [1:0] CM_INSERT    = 2'd1;
  localparam logic [1:0] CM_POP_FRONT = 2'd2;
  localparam logic [1:0] CM_WRITE     = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
  } sal_cell_ctrl_t;

endpackage

>>> rtl/core/shifting_array_list.sv
// ----------------------------------------------------------------------------
// shifting_array_list: fixed-capacity ordered list of signed 32-bit values
// A chain of element cells that shift up or down together, plus a count.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry func, position and value; each accepted beat yields
//   exactly one result beat with read_value, count and status.
//   Both channels use valid/stall; a beat moves when valid is high and stall
//   is low. The receiver drives stall.
//   The result of a beat accepted at edge N is on the output register after
//   edge N. One beat per cycle is sustained while the receiver does not stall:
//   every operation, shifts included, finishes in the cycle it is accepted,
//   because all cells of the chain load their neighbor at once.
//   The read path is a select over the first min(CAPACITY, 32) cells.
//   When the receiver stalls, the result holds in the output register and
//   in_stall is raised until that result is taken; a new beat is accepted
//   in the same cycle the waiting result leaves.
//   Reset clears every cell to zero, the count to zero and the output valid.
//   Full, empty and out-of-range operations leave the list unchanged and
//   report it in status.
// ----------------------------------------------------------------------------
module shifting_array_list
  import sal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   out_read_value,
  output logic [COUNT_OUT_W-1:0]     out_count,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CMP_W-1:0] CAP_CMP  = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_read_value_r;
  logic [COUNT_OUT_W-1:0]    out_count_r;
  logic [STATUS_W-1:0]       out_status_r;

  logic                      in_accept;
  logic                      out_accept;
  logic                      full;
  logic                      empty;
  logic                      in_range;
  logic [CMP_W-1:0]          pos_cmp;
  logic [CMP_W-1:0]          count_cmp;
  logic [CMP_W-1:0]          count_nxt_cmp;
  logic [CNT_W-1:0]          ins_pos;
  logic [1:0]                mode;
  logic [CNT_W-1:0]          sel;
  logic [STATUS_W-1:0]       status;
  logic signed [DATA_W-1:0]  rd_cell;
  logic signed [DATA_W-1:0]  rd_value;
  sal_cell_ctrl_t            ctrl;

  logic signed [DATA_W-1:0]  cell_q [CAPACITY];

  assign out_accept = out_valid_r && !out_stall;
  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;

  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign pos_cmp   = CMP_W'(in_position);
  assign count_cmp = CMP_W'(count_r);
  assign in_range  = (pos_cmp < CAP_CMP);
  // clamp an insert past the end to an append
  assign ins_pos   = (pos_cmp >= count_cmp) ? count_r : CNT_W'(pos_cmp);

  always_comb begin
    rd_cell = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_cmp == CMP_W'(i)) begin
        rd_cell = cell_q[i];
      end
    end
  end

  always_comb begin
    mode      = CM_HOLD;
    sel       = '0;
    count_nxt = count_r;
    status    = ST_DONE;
    rd_value  = '0;
    unique case (in_func)
      FN_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mode      = CM_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mode      = CM_INSERT;
          sel       = count_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          mode      = CM_POP_FRONT;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mode      = CM_INSERT;
          sel       = ins_pos;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_READ: begin
        if (in_range) begin
          rd_value = rd_cell;
        end else begin
          status = ST_RANGE;
        end
      end
      FN_WRITE: begin
        if (in_range) begin
          mode = CM_WRITE;
          sel  = CNT_W'(pos_cmp);
        end else begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign count_nxt_cmp = CMP_W'(count_nxt);

  // cells act only on an accepted beat
  assign ctrl.mode  = in_accept ? mode : CM_HOLD;
  assign ctrl.value = in_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] lo_d;
    logic signed [DATA_W-1:0] hi_d;

    if (i == 0) begin : g_lo_edge
      assign lo_d = '0;
    end else begin : g_lo
      assign lo_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi_edge
      assign hi_d = '0;
    end else begin : g_hi
      assign hi_d = cell_q[i+1];
    end

    sal_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .sel    (sel),
      .count  (count_r),
      .lo_d   (lo_d),
      .hi_d   (hi_d),
      .data_q (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_read_value_r <= rd_value;
      out_count_r      <= count_nxt_cmp[COUNT_OUT_W-1:0];
      out_status_r     <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("element count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_pop_front_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_func == FN_POP_FRONT && !empty)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop front did not drop the count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && full && (in_func == FN_PUSH_FRONT || in_func == FN_PUSH_BACK
      || in_func == FN_INSERT)) |=> (out_status == ST_FULL && $stable(count_r)))
    else $error("push on full list not rejected");

endmodule

>>> rtl/core/sal_cell.sv
// ----------------------------------------------------------------------------
// sal_cell: one element cell of the shifting array list
// Holds one element and takes a new value from the broadcast control or from
// its lower or upper neighbor.
// ----------------------------------------------------------------------------
module sal_cell
  import sal_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sal_cell_ctrl_t           ctrl,
  input  logic [CNT_W-1:0]         sel,
  input  logic [CNT_W-1:0]         count,
  input  logic signed [DATA_W-1:0] lo_d,
  input  logic signed [DATA_W-1:0] hi_d,
  output logic signed [DATA_W-1:0] data_q
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_IX = CNT_W'(IDX + 1);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.mode)
      CM_INSERT: begin
        if (MY_IDX == sel) begin
          data_nxt = ctrl.value;
        end else if (MY_IDX > sel && MY_IDX <= count) begin
          data_nxt = lo_d;
        end
      end
      CM_POP_FRONT: begin
        // the top valid cell keeps its old contents
        if (NEXT_IX < count) begin
          data_nxt = hi_d;
        end
      end
      CM_WRITE: begin
        if (MY_IDX == sel) begin
          data_nxt = ctrl.value;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_q = data_r;

endmodule
